/* hdl/plst_pkg.sv */
// ----------------------------------------------------------------------------
// plst_pkg
// Shared sizes, codes and types for the positional list store: slot and
// count widths, operation and status codes, and the link RAM write word.
// ----------------------------------------------------------------------------
package plst_pkg;

   // Number of list slots
   localparam int CAPACITY = 16;

   localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int LEN_W   = 5;

   // Width for comparing a position against the entry count
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_END   = 3'd1,
      MODE_INS_AT    = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_END   = 3'd4,
      MODE_DEL_AT    = 3'd5,
      MODE_DUMP      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_BADPOS = 2'd3
   } status_type;

   // One write into the link RAM: value and link fields enable separately
   typedef struct packed {
      logic                value_en;
      logic                link_en;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  value;
      logic [SLOT_W-1:0]   link;
   } ram_wr_type;

endpackage

/* hdl/plst_link_ram.sv */
// ----------------------------------------------------------------------------
// plst_link_ram
// Slot storage for the list: stored value and successor link per slot.
// One write port with per-field enables, one read port with registered data.
// ----------------------------------------------------------------------------
module plst_link_ram
   import plst_pkg::*;
(
   input  logic                clock,
   input  ram_wr_type          wr,
   input  logic [SLOT_W-1:0]   rd_addr,
   output logic [VALUE_W-1:0]  rd_value,
   output logic [SLOT_W-1:0]   rd_next
);

   logic [VALUE_W-1:0] entry_mem [CAPACITY];
   logic [SLOT_W-1:0]  link_mem  [CAPACITY];
   logic [VALUE_W-1:0] rd_value_ff;
   logic [SLOT_W-1:0]  rd_next_ff;

   // Write the selected fields of one slot
   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         entry_mem[wr.slot] <= wr.value;
      end
      if (wr.link_en) begin
         link_mem[wr.slot] <= wr.link;
      end
   end

   // Read one slot every cycle; data shows up the next cycle
   always_ff @(posedge clock) begin
      rd_value_ff <= entry_mem[rd_addr];
      rd_next_ff  <= link_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;

endmodule

/* hdl/plst_slot_alloc.sv */
// ----------------------------------------------------------------------------
// plst_slot_alloc
// Free-slot map. Offers the lowest-numbered free slot, marks a slot used on
// claim and free again on release.
// ----------------------------------------------------------------------------
module plst_slot_alloc
   import plst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                claim_en,
   input  logic [SLOT_W-1:0]   claim_slot,
   input  logic                release_en,
   input  logic [SLOT_W-1:0]   release_slot,
   output logic [SLOT_W-1:0]   low_slot
);

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;

   // Update the map
   always_comb begin
      free_in = free_ff;
      if (claim_en) begin
         free_in[claim_slot] = 1'b0;
      end
      if (release_en) begin
         free_in[release_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

   // Pick the lowest free slot
   always_comb begin
      low_slot = '0;
      for (int s = CAPACITY - 1; s >= 0; s--) begin
         if (free_ff[s]) begin
            low_slot = SLOT_W'(s);
         end
      end
   end

   // Only a free slot is claimed, only a used slot is released
   a_claim_free : assert property (@(posedge clock) disable iff (reset)
      claim_en |-> free_ff[claim_slot])
      else $error("claimed slot was not free");

   a_release_used : assert property (@(posedge clock) disable iff (reset)
      release_en |-> !free_ff[release_slot])
      else $error("released slot was already free");

   a_no_double : assert property (@(posedge clock) disable iff (reset)
      claim_en && release_en |-> claim_slot != release_slot)
      else $error("slot claimed and released together");

endmodule

/* hdl/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values kept as linked slots. Each request
// word inserts, deletes or dumps; inserts and deletes answer one status
// word, a dump answers one word per entry (or one empty status).
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | req_valid/ready, mode,value,pos | in
//   response| rsp_valid/ready, element,status,last,length | out
//
// Walks step one link per cycle through the single RAM read port: insert at
// index k > 0 steps k-1 links, delete at index k steps k links, a front
// insert steps none; mode 7 is dropped.
// Reset is synchronous; the slot RAM is not cleared, only linked slots are read.
// A stalled response holds the sequencer; a request is taken only in idle.
// ----------------------------------------------------------------------------
module positional_list_store
   import plst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_element,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_last,
   output logic [LEN_W-1:0]           rsp_length
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_INS_NEW,
      ST_INS_LINK,
      ST_REPLY,
      ST_DUMP
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   first_ff, first_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic [SLOT_W-1:0]   new_ff, new_in;
   logic [SLOT_W-1:0]   link_ff, link_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                del_ff, del_in;
   logic                front_ff, front_in;
   status_type          status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_element_ff, rsp_element_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;

   logic [SLOT_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_value;
   logic [SLOT_W-1:0]   rd_next;
   ram_wr_type          wr;
   logic                claim_en;
   logic                release_en;
   logic [SLOT_W-1:0]   release_slot;
   logic [SLOT_W-1:0]   low_slot;

   mode_type            req_op;
   logic [CMP_W-1:0]    count_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    ins_pos;
   logic [CMP_W-1:0]    del_pos;
   logic                out_free;

   plst_link_ram u_ram (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next)
   );

   plst_slot_alloc u_alloc (
      .clock        (clock),
      .reset        (reset),
      .claim_en     (claim_en),
      .claim_slot   (new_ff),
      .release_en   (release_en),
      .release_slot (release_slot),
      .low_slot     (low_slot)
   );

   // Resolve the effective index of each request
   assign req_op    = mode_type'(req_mode);
   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_position);

   always_comb begin
      unique case (req_op)
         MODE_INS_FRONT: ins_pos = '0;
         MODE_INS_END:   ins_pos = count_ext;
         default:        ins_pos = pos_ext;
      endcase
      unique case (req_op)
         MODE_DEL_FRONT: del_pos = '0;
         MODE_DEL_END:   del_pos = count_ext - CMP_W'(1);
         default:        del_pos = pos_ext;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      first_in       = first_ff;
      steps_in       = steps_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      new_in         = new_ff;
      link_in        = link_ff;
      value_in       = value_ff;
      del_in         = del_ff;
      front_in       = front_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_element_in = rsp_element_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_length_in  = rsp_length_ff;
      rd_addr        = cur_ff;
      wr             = '0;
      claim_en       = 1'b0;
      release_en     = 1'b0;
      release_slot   = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Start every walk at the front slot
            rd_addr = first_ff;
            cur_in  = first_ff;
            if (req_valid) begin
               unique case (req_op)
                  MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_REPLY;
                     end else if (ins_pos > count_ext) begin
                        status_in = STATUS_BADPOS;
                        state_in  = ST_REPLY;
                     end else begin
                        new_in   = low_slot;
                        value_in = req_value;
                        del_in   = 1'b0;
                        if (ins_pos == '0) begin
                           front_in = 1'b1;
                           link_in  = first_ff;
                           state_in = ST_INS_NEW;
                        end else begin
                           front_in = 1'b0;
                           steps_in = CNT_W'(ins_pos - CMP_W'(1));
                           state_in = ST_WALK;
                        end
                     end
                  end
                  MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_AT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_REPLY;
                     end else if (del_pos >= count_ext) begin
                        status_in = STATUS_BADPOS;
                        state_in  = ST_REPLY;
                     end else begin
                        del_in   = 1'b1;
                        front_in = (del_pos == '0);
                        steps_in = CNT_W'(del_pos);
                        state_in = ST_WALK;
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_REPLY;
                     end else begin
                        steps_in = count_ff;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     // Unused mode: drop the word
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (steps_ff == '0) begin
               if (!del_ff) begin
                  // Arrived at the predecessor of the new entry
                  link_in  = rd_next;
                  state_in = ST_INS_NEW;
               end else begin
                  // Arrived at the doomed entry: unlink and free it
                  release_en = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
                  status_in  = STATUS_OK;
                  if (front_ff) begin
                     first_in = rd_next;
                  end else begin
                     wr.link_en = 1'b1;
                     wr.slot    = prev_ff;
                     wr.link    = rd_next;
                  end
                  state_in = ST_REPLY;
               end
            end else begin
               // Advance one link
               steps_in = steps_ff - CNT_W'(1);
               prev_in  = cur_ff;
               cur_in   = rd_next;
               rd_addr  = rd_next;
            end
         end

         ST_INS_NEW: begin
            // Fill the new slot and take it from the free map
            wr.value_en = 1'b1;
            wr.link_en  = 1'b1;
            wr.slot     = new_ff;
            wr.value    = value_ff;
            wr.link     = link_ff;
            claim_en    = 1'b1;
            status_in   = STATUS_OK;
            if (front_ff) begin
               first_in = new_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_REPLY;
            end else begin
               state_in = ST_INS_LINK;
            end
         end

         ST_INS_LINK: begin
            // Point the predecessor at the new slot
            wr.link_en = 1'b1;
            wr.slot    = cur_ff;
            wr.link    = new_ff;
            count_in   = count_ff + CNT_W'(1);
            state_in   = ST_REPLY;
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = '0;
               rsp_status_in  = status_ff;
               rsp_last_in    = 1'b1;
               rsp_length_in  = LEN_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end

         ST_DUMP: begin
            // Emit the current entry, then advance
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = rd_value;
               rsp_status_in  = STATUS_OK;
               rsp_last_in    = (steps_ff == CNT_W'(1));
               rsp_length_in  = LEN_W'(count_ff);
               steps_in       = steps_ff - CNT_W'(1);
               if (steps_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in  = rd_next;
                  rd_addr = rd_next;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      steps_ff       <= steps_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      new_ff         <= new_in;
      link_ff        <= link_in;
      value_ff       <= value_in;
      del_ff         <= del_in;
      front_ff       <= front_in;
      status_ff      <= status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_length  = rsp_length_ff;

   // Entry count never passes the slot count
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A walk never runs past the last entry
   a_walk_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> steps_ff < count_ff)
      else $error("walk runs beyond list end");

   // A dump always has an entry left to emit
   a_dump_left : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> steps_ff != '0 && steps_ff <= count_ff)
      else $error("dump counter out of range");

endmodule
